>>> sv/lwsc_pkg.sv
`timescale 1ns / 1ps
package lwsc_pkg;
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    localparam logic [2:0] ACT_READ_HIT   = 3'd0;
    localparam logic [2:0] ACT_BYPASS     = 3'd1;
    localparam logic [2:0] ACT_WRITEBACK  = 3'd2;
    localparam logic [2:0] ACT_FILL       = 3'd3;
    localparam logic [2:0] ACT_GRANT      = 3'd4;
    localparam logic [2:0] ACT_FLUSH_DONE = 3'd5;
    localparam logic [2:0] ACT_ERROR      = 3'd6;

    localparam logic [1:0] REG_SECTOR_COUNT = 2'd0;
    localparam logic [1:0] REG_SEC_BYTES    = 2'd1;
    localparam logic [1:0] REG_SLOTS_IN_USE = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  slot;
        logic [30:0] target_sector;
        logic        last;
    } result_t;
endpackage

>>> sv/lru_writeback_sector_cache.sv
`timescale 1ns / 1ps
// A read or write result leaves after the scan of the enabled slots, behind any writeback
// or fill ahead of the grant; an error passes through the ST_ONE state and the output register.
// Only one read or write is handled at a time: a new transfer is taken only in the idle state,
// and one shared tag/stamp compare unit walks the slot memories one entry per cycle.
// A flush sends one writeback per dirty enabled slot, or a flush-done result when nothing is dirty.
// Reset clears valid and dirty flags and the write clock; tags and stamps are undefined.
module lru_writeback_sector_cache
    import lwsc_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int MAX_SECTOR_BYTES = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // sector[30:0], byte_offset[42:31], byte_length[55:43]
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // slot[5:0], target_sector[36:6]
    output logic [2:0]  m_axis_tuser,   // action
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WB    = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_GRANT = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;
    localparam logic [2:0] ST_ONE   = 3'd6;
    localparam logic [2:0] ST_FTAG  = 3'd7;

    logic [30:0] sector_count_reg;
    logic [12:0] sec_bytes_reg;
    logic [6:0]  slots_in_use_reg;

    logic [30:0] tag_mem [SLOTS];
    logic [31:0] stamp_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg, dirty_reg;
    logic [31:0] clock_reg;

    logic [2:0]  state_reg;
    logic [1:0]  kind_reg;
    logic [30:0] sec_reg;
    logic        full_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic        hit_reg, inv_reg;
    logic [IW-1:0] hit_idx_reg, vic_reg;
    logic [31:0] best_reg;
    logic [30:0] wb_tag_reg;
    logic [IW-1:0] wb_idx_reg;
    logic        pend_reg;
    result_t     one_reg;

    logic        push;
    result_t     push_data;
    logic        ofull;
    result_t     odata;
    logic [CW-1:0] n_now;
    logic [IW-1:0] cur;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] upd_idx;
    logic [30:0] tag_rd_reg;
    logic [31:0] stamp_rd_reg;
    logic [IW-1:0] rd_idx_reg;
    logic        rd_ok_reg;
    logic        in_go;
    logic        found;
    logic [13:0] win;
    logic        err;

    assign cur = idx_reg[IW-1:0];
    assign upd_idx = hit_reg ? hit_idx_reg : vic_reg;
    // point the read port at the victim once the scan has run past the last slot
    assign rd_addr = (state_reg == ST_WB || (state_reg == ST_SCAN && idx_reg == n_reg))
                   ? vic_reg : cur;
    assign found = (idx_reg < n_reg) && valid_reg[cur] && dirty_reg[cur];

    always_comb
    begin
        if (slots_in_use_reg == 7'd0)
            n_now = CW'(1);
        else if (32'(slots_in_use_reg) > SLOTS)
            n_now = CW'(SLOTS);
        else
            n_now = CW'(slots_in_use_reg);
    end

    assign win = 14'(s_axis_tdata[42:31]) + 14'(s_axis_tdata[55:43]);
    assign err = (s_axis_tuser == KIND_BAD) || (sec_bytes_reg == 13'd0)
              || (32'(sec_bytes_reg) > MAX_SECTOR_BYTES)
              || (s_axis_tdata[30:0] >= sector_count_reg)
              || (win > 14'(sec_bytes_reg));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_go = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= '0;
            sec_bytes_reg    <= 13'd512;
            slots_in_use_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SECTOR_COUNT: sector_count_reg <= cfg_data;
                REG_SEC_BYTES:    sec_bytes_reg    <= cfg_data[12:0];
                REG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Registered tag and stamp read: the address is issued in the cycle before the compare.
    always_ff @(posedge clk)
    begin
        tag_rd_reg   <= tag_mem[rd_addr];
        stamp_rd_reg <= stamp_mem[rd_addr];
        rd_idx_reg   <= rd_addr;
        if (state_reg == ST_GRANT && push && kind_reg == KIND_WRITE)
        begin
            if (!hit_reg)
                tag_mem[vic_reg] <= sec_reg;
            stamp_mem[upd_idx] <= clock_reg + 32'd1;
        end
    end

    always_comb
    begin
        push = 1'b0;
        push_data = one_reg;
        unique case (state_reg)
            ST_ONE:
                push = !ofull;
            ST_WB:
            begin
                push = !ofull;
                push_data = '{ACT_WRITEBACK, 6'(vic_reg), tag_rd_reg, 1'b0};
            end
            ST_FILL:
            begin
                push = !ofull;
                push_data = '{ACT_FILL, 6'(vic_reg), sec_reg, 1'b0};
            end
            ST_GRANT:
            begin
                push = !ofull;
                push_data = '{(kind_reg == KIND_READ) ? ACT_READ_HIT : ACT_GRANT,
                              6'(upd_idx), sec_reg, 1'b1};
            end
            ST_FLUSH:
            begin
                // release the held writeback once the next one is found or the scan ends
                push = pend_reg && (found || idx_reg == n_reg) && !ofull;
                push_data = '{ACT_WRITEBACK, 6'(wb_idx_reg), wb_tag_reg, idx_reg == n_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            clock_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (in_go)
                    begin
                        kind_reg <= s_axis_tuser;
                        sec_reg  <= s_axis_tdata[30:0];
                        full_reg <= (s_axis_tdata[42:31] == 12'd0)
                                 && (s_axis_tdata[55:43] == sec_bytes_reg);
                        n_reg    <= n_now;
                        idx_reg  <= '0;
                        hit_reg  <= 1'b0;
                        inv_reg  <= 1'b0;
                        vic_reg  <= '0;
                        best_reg <= '1;
                        pend_reg <= 1'b0;
                        rd_ok_reg <= 1'b0;
                        if (s_axis_tuser == KIND_FLUSH)
                            state_reg <= ST_FLUSH;
                        else if (err)
                        begin
                            one_reg <= '{ACT_ERROR, 6'd0, s_axis_tdata[30:0], 1'b1};
                            state_reg <= ST_ONE;
                        end
                        else
                            state_reg <= ST_SCAN;
                    end
                ST_SCAN:
                begin
                    // compare stage works on the entry read last cycle
                    if (idx_reg < n_reg)
                        idx_reg <= idx_reg + CW'(1);
                    rd_ok_reg <= idx_reg < n_reg;
                    if (rd_ok_reg && !hit_reg)
                    begin
                        if (valid_reg[rd_idx_reg] && tag_rd_reg == sec_reg)
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= rd_idx_reg;
                        end
                        if (!inv_reg)
                        begin
                            if (!valid_reg[rd_idx_reg])
                            begin
                                inv_reg <= 1'b1;
                                vic_reg <= rd_idx_reg;
                            end
                            else if (stamp_rd_reg < best_reg)
                            begin
                                best_reg <= stamp_rd_reg;
                                vic_reg  <= rd_idx_reg;
                            end
                        end
                    end
                    if (!rd_ok_reg && idx_reg == n_reg && n_reg != '0 && idx_reg != '0)
                    begin
                        idx_reg <= '0;
                        if (hit_reg)
                            state_reg <= ST_GRANT;
                        else if (kind_reg == KIND_READ)
                        begin
                            one_reg <= '{ACT_BYPASS, 6'd0, sec_reg, 1'b1};
                            state_reg <= ST_ONE;
                        end
                        else if (valid_reg[vic_reg] && dirty_reg[vic_reg])
                            state_reg <= ST_WB;
                        else
                            state_reg <= full_reg ? ST_GRANT : ST_FILL;
                    end
                end
                ST_WB:
                    if (push)
                        state_reg <= full_reg ? ST_GRANT : ST_FILL;
                ST_FILL:
                    if (push)
                        state_reg <= ST_GRANT;
                ST_GRANT:
                    if (push)
                    begin
                        if (kind_reg == KIND_WRITE)
                        begin
                            valid_reg[upd_idx] <= 1'b1;
                            dirty_reg[upd_idx] <= 1'b1;
                            clock_reg <= clock_reg + 32'd1;
                        end
                        state_reg <= ST_IDLE;
                    end
                ST_FLUSH:
                begin
                    if (idx_reg < n_reg)
                    begin
                        if (!found)
                            idx_reg <= idx_reg + CW'(1);
                        else if (!pend_reg || push)
                        begin
                            // tag of this slot lands in the read register at this edge
                            idx_reg    <= idx_reg + CW'(1);
                            pend_reg   <= 1'b1;
                            wb_idx_reg <= cur;
                            dirty_reg[cur] <= 1'b0;
                            state_reg  <= ST_FTAG;
                        end
                    end
                    else if (!pend_reg)
                    begin
                        one_reg <= '{ACT_FLUSH_DONE, 6'd0, 31'd0, 1'b1};
                        state_reg <= ST_ONE;
                    end
                    else if (push)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FTAG:
                begin
                    wb_tag_reg <= tag_rd_reg;
                    state_reg  <= ST_FLUSH;
                end
                ST_ONE:
                    if (push)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    lwsc_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .push_data     (push_data),
        .full          (ofull),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_data   (odata)
    );

    assign m_axis_tuser = odata.action;
    assign m_axis_tdata = {3'd0, odata.target_sector, odata.slot};
    assign m_axis_tlast = odata.last;

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_go |=> !s_axis_tready) else $error("accepted while busy");
    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        (clock_reg != $past(clock_reg)) |-> ($past(state_reg) == ST_GRANT))
        else $error("write clock moved outside grant");
    a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg & ~valid_reg) == '0) else $error("dirty slot not valid");
endmodule

>>> sv/lwsc_out_reg.sv
`timescale 1ns / 1ps
// Single output holding register between the sequencer and the result stream.
module lwsc_out_reg
    import lwsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    output result_t m_axis_data
);
    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (push)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg <= push_data;
    end

    assign full          = valid_reg && !m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_data   = data_reg;

    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into held result");
endmodule
